@@ hdl/bgl_pkg.sv @@
// ----------------------------------------------------------------------------
// bgl_pkg
// Shared constants and types for the bitmap text glyph layout core.
// ----------------------------------------------------------------------------
package bgl_pkg;

  localparam int MAX_CHARS     = 1024;
  localparam int GLYPH_ENTRIES = 128;
  localparam int ADDR_W        = $clog2(GLYPH_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_CHARS + 1);
  localparam int ENTRY_W       = 49;

  localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] CFG_FIRST_CODE  = 3'd2;
  localparam logic [2:0] CFG_LAST_CODE   = 3'd3;
  localparam logic [2:0] CFG_SPACE_WIDTH = 3'd4;
  localparam logic [2:0] CFG_LINE_HEIGHT = 3'd5;

  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef struct packed {
    logic [8:0]  descent;
    logic [7:0]  height;
    logic [7:0]  width;
    logic [11:0] tex_y;
    logic [11:0] tex_x;
  } glyph_entry_t;

  typedef struct packed {
    logic is_text;
    logic starts;
    logic is_nl;
    logic is_space;
    logic is_tab;
    logic is_cr;
    logic is_draw;
  } char_class_t;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [6:0]  first_code;
    logic [6:0]  last_code;
    logic [7:0]  space_width;
    logic [7:0]  line_height;
  } layout_cfg_t;

endpackage

@@ hdl/bitmap_text_glyph_layout_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_text_glyph_layout_core
// Lays out text bytes as bitmap glyph rectangles from a loaded glyph table.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       sink       in_valid_i/in_ready_o  kind, code, starts_text, load_*
// out      source     out_valid_o/out_ready_i screen_x/y, rect_*, source_*, number
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; the table RAM is read at
// accept, and the cursor add then puts a drawn glyph into the output register.
// Loads write the RAM at accept, so a following character sees them at once.
// A full output register holds a glyph item, and the input waits behind it.
// Other items never wait on the output; reset is asynchronous.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_layout_core import bgl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  code_i,
  input  logic        starts_text_i,
  input  logic [11:0] load_tex_x_i,
  input  logic [11:0] load_tex_y_i,
  input  logic [7:0]  load_width_i,
  input  logic [7:0]  load_height_i,
  input  logic [8:0]  load_descent_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] screen_x_o,
  output logic [15:0] screen_y_o,
  output logic [7:0]  rect_width_o,
  output logic [7:0]  rect_height_o,
  output logic [11:0] source_x_o,
  output logic [11:0] source_y_o,
  output logic [9:0]  glyph_number_o
);

  layout_cfg_t  cfg_q, cfg_d;
  logic         accept, advance, we, re, s1_valid;
  logic [ADDR_W-1:0] waddr, raddr;
  glyph_entry_t wentry, rentry;
  char_class_t  s1_class;
  logic [ENTRY_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X:    cfg_d.origin_x    = cfg_data_i;
        CFG_ORIGIN_Y:    cfg_d.origin_y    = cfg_data_i;
        CFG_FIRST_CODE:  cfg_d.first_code  = cfg_data_i[6:0];
        CFG_LAST_CODE:   cfg_d.last_code   = cfg_data_i[6:0];
        CFG_SPACE_WIDTH: cfg_d.space_width = cfg_data_i[7:0];
        CFG_LINE_HEIGHT: cfg_d.line_height = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= 16'd0;
      cfg_q.origin_y    <= 16'd0;
      cfg_q.first_code  <= 7'd33;
      cfg_q.last_code   <= 7'd126;
      cfg_q.space_width <= 8'd8;
      cfg_q.line_height <= 8'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !s1_valid || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign wentry.descent = load_descent_i;
  assign wentry.height  = load_height_i;
  assign wentry.width   = load_width_i;
  assign wentry.tex_y   = load_tex_y_i;
  assign wentry.tex_x   = load_tex_x_i;

  bgl_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .advance_i     (advance),
    .kind_i        (kind_i),
    .code_i        (code_i),
    .starts_text_i (starts_text_i),
    .we_o          (we),
    .waddr_o       (waddr),
    .re_o          (re),
    .raddr_o       (raddr),
    .s1_valid_o    (s1_valid),
    .s1_class_o    (s1_class)
  );

  bgl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GLYPH_ENTRIES)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rentry = glyph_entry_t'(rdata);

  bgl_cursor u_cursor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .s1_valid_i     (s1_valid),
    .s1_class_i     (s1_class),
    .entry_i        (rentry),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .rect_width_o   (rect_width_o),
    .rect_height_o  (rect_height_o),
    .source_x_o     (source_x_o),
    .source_y_o     (source_y_o),
    .glyph_number_o (glyph_number_o)
  );

endmodule

@@ hdl/bgl_ram.sv @@
// ----------------------------------------------------------------------------
// bgl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bgl_classify.sv @@
// ----------------------------------------------------------------------------
// bgl_classify
// Front stage: decodes the accepted item, drives the table read and, for a load,
// the table write, and registers the character class for the cursor stage.
// ----------------------------------------------------------------------------
module bgl_classify import bgl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  layout_cfg_t       cfg_i,
  input  logic              accept_i,
  input  logic              advance_i,
  input  logic              kind_i,
  input  logic [7:0]        code_i,
  input  logic              starts_text_i,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o,
  output logic              s1_valid_o,
  output char_class_t       s1_class_o
);

  logic        s1_valid_q, s1_valid_d;
  char_class_t cls_q, cls_d;
  logic [7:0]  idx;
  logic        in_range;

  assign idx = {1'b0, code_i[6:0]} - {1'b0, cfg_i.first_code};

  assign in_range = !code_i[7] && (code_i[6:0] >= cfg_i.first_code) &&
                    (code_i[6:0] <= cfg_i.last_code) &&
                    ({1'b0, idx} < 9'(GLYPH_ENTRIES));

  always_comb begin
    cls_d          = '0;
    cls_d.is_text  = (kind_i == KIND_TEXT);
    cls_d.starts   = starts_text_i;
    cls_d.is_nl    = (code_i == CHR_NL);
    cls_d.is_space = (code_i == CHR_SPACE);
    cls_d.is_tab   = (code_i == CHR_TAB);
    cls_d.is_cr    = (code_i == CHR_CR);
    cls_d.is_draw  = in_range && !cls_d.is_nl && !cls_d.is_space &&
                     !cls_d.is_tab && !cls_d.is_cr;
  end

  assign we_o    = accept_i && (kind_i == KIND_LOAD) &&
                   ({1'b0, code_i} < 9'(GLYPH_ENTRIES));
  assign waddr_o = code_i[ADDR_W-1:0];
  assign re_o    = accept_i;
  assign raddr_o = idx[ADDR_W-1:0];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (advance_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cls_q <= cls_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_class_o = cls_q;

endmodule

@@ hdl/bgl_cursor.sv @@
// ----------------------------------------------------------------------------
// bgl_cursor
// Cursor stage: applies the class and the glyph entry read from the table
// to the cursor and counters, and holds the result item in an output register.
// ----------------------------------------------------------------------------
module bgl_cursor import bgl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  layout_cfg_t  cfg_i,
  input  logic         s1_valid_i,
  input  char_class_t  s1_class_i,
  input  glyph_entry_t entry_i,
  output logic         advance_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [15:0]  screen_x_o,
  output logic [15:0]  screen_y_o,
  output logic [7:0]   rect_width_o,
  output logic [7:0]   rect_height_o,
  output logic [11:0]  source_x_o,
  output logic [11:0]  source_y_o,
  output logic [9:0]   glyph_number_o
);

  logic [15:0]      cx_q, cx_d, cy_q, cy_d;
  logic [CNT_W-1:0] chars_q, chars_d;
  logic [9:0]       glyphs_q, glyphs_d;
  logic             out_valid_q, out_valid_d;

  logic [15:0]      base_x, base_y;
  logic [CNT_W-1:0] base_cnt;
  logic [9:0]       base_gl;
  logic             live, draw, slot_free, adv;

  logic [15:0] sx_q, sy_q;
  logic [7:0]  w_q, h_q;
  logic [11:0] tx_q, ty_q;
  logic [9:0]  gn_q;

  assign base_x   = s1_class_i.starts ? cfg_i.origin_x : cx_q;
  assign base_y   = s1_class_i.starts ? cfg_i.origin_y : cy_q;
  assign base_cnt = s1_class_i.starts ? '0 : chars_q;
  assign base_gl  = s1_class_i.starts ? '0 : glyphs_q;

  assign live      = s1_class_i.is_text && (base_cnt < CNT_W'(MAX_CHARS));
  assign draw      = live && s1_class_i.is_draw;
  assign slot_free = !out_valid_q || out_ready_i;
  assign adv       = s1_valid_i && (!draw || slot_free);

  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    chars_d  = chars_q;
    glyphs_d = glyphs_q;
    if (adv && s1_class_i.is_text) begin
      cx_d     = base_x;
      cy_d     = base_y;
      chars_d  = base_cnt;
      glyphs_d = base_gl;
      if (live) begin
        chars_d = base_cnt + 1'b1;
        if (s1_class_i.is_nl) begin
          cx_d = cfg_i.origin_x;
          cy_d = base_y - {8'd0, cfg_i.line_height};
        end else if (s1_class_i.is_space) begin
          cx_d = base_x + {8'd0, cfg_i.space_width};
        end else if (s1_class_i.is_tab) begin
          cx_d = base_x + {6'd0, cfg_i.space_width, 2'b00};
        end else if (s1_class_i.is_draw) begin
          cx_d     = base_x + {8'd0, entry_i.width};
          glyphs_d = base_gl + 1'b1;
        end else if (!s1_class_i.is_cr) begin
          cx_d = base_x + {8'd0, cfg_i.space_width};
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && draw) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      chars_q     <= '0;
      glyphs_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      chars_q     <= chars_d;
      glyphs_q    <= glyphs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && draw) begin
      sx_q <= base_x;
      sy_q <= base_y + {{7{entry_i.descent[8]}}, entry_i.descent};
      w_q  <= entry_i.width;
      h_q  <= entry_i.height;
      tx_q <= entry_i.tex_x;
      ty_q <= entry_i.tex_y;
      gn_q <= base_gl;
    end
  end

  assign advance_o      = adv;
  assign out_valid_o    = out_valid_q;
  assign screen_x_o     = sx_q;
  assign screen_y_o     = sy_q;
  assign rect_width_o   = w_q;
  assign rect_height_o  = h_q;
  assign source_x_o     = tx_q;
  assign source_y_o     = ty_q;
  assign glyph_number_o = gn_q;

endmodule

@@ hdl/bgl_checker.sv @@
// ----------------------------------------------------------------------------
// bgl_checker
// Port-level checks for the bitmap text glyph layout core, bound to the top.
// ----------------------------------------------------------------------------
module bgl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] screen_x_o,
  input logic [15:0] screen_y_o,
  input logic [9:0]  glyph_number_o
);

  // empty output register never holds back the input side
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> in_ready_o
  ) else $error("input stalled with empty output");

  a_cfg_always_ready: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cfg_ready_o
  ) else $error("config port not ready");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(screen_x_o) &&
      $stable(screen_y_o) && $stable(glyph_number_o)
  ) else $error("stalled output item changed");

endmodule

bind bitmap_text_glyph_layout_core bgl_checker u_bgl_checker (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks bitmap_text_glyph_layout_core. Glyph table loads and text bytes go
// in over a valid/ready channel with random gaps and several register
// settings. A scoreboard object tracks its own glyph store and pen position
// and compares every glyph rectangle against the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import bgl_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic        starts;
    logic [11:0] tex_x;
    logic [11:0] tex_y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [8:0]  descent;
  } text_item_t;

  typedef struct packed {
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [11:0] source_x;
    logic [11:0] source_y;
    logic [9:0]  glyph_number;
  } glyph_rect_t;

  localparam int ITEM_W = $bits(text_item_t);
  localparam int SETTLE_CYCLES = 6;

  class glyph_layout_scoreboard;
    layout_cfg_t   cfg;
    glyph_entry_t  glyph_mem [GLYPH_ENTRIES];
    logic [15:0]   pen_x;
    logic [15:0]   pen_y;
    int unsigned   chars_seen;
    int unsigned   glyphs_drawn;
    glyph_rect_t   pending_glyphs[$];
    int unsigned   errors;

    function new();
      foreach (glyph_mem[i]) glyph_mem[i] = '0;
      cfg = '{origin_x: 16'd0, origin_y: 16'd0, first_code: 7'd33, last_code: 7'd126,
              space_width: 8'd8, line_height: 8'd16};
      pen_x = '0;
      pen_y = '0;
      chars_seen = 0;
      glyphs_drawn = 0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function string show(glyph_rect_t r);
      return $sformatf("x=%0d y=%0d w=%0d h=%0d sx=%0d sy=%0d n=%0d", r.screen_x,
                       r.screen_y, r.rect_width, r.rect_height, r.source_x, r.source_y,
                       r.glyph_number);
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_ORIGIN_X:    cfg.origin_x = data;
        CFG_ORIGIN_Y:    cfg.origin_y = data;
        CFG_FIRST_CODE:  cfg.first_code = data[6:0];
        CFG_LAST_CODE:   cfg.last_code = data[6:0];
        CFG_SPACE_WIDTH: cfg.space_width = data[7:0];
        CFG_LINE_HEIGHT: cfg.line_height = data[7:0];
        default: ;
      endcase
    endfunction

    function void accept_item(text_item_t it);
      glyph_entry_t g;
      glyph_rect_t  r;
      int           idx;
      if (it.kind == KIND_LOAD) begin
        if (it.code < GLYPH_ENTRIES)
          glyph_mem[it.code] = '{descent: it.descent, height: it.height, width: it.width,
                                 tex_y: it.tex_y, tex_x: it.tex_x};
        return;
      end
      if (it.starts) begin
        pen_x = cfg.origin_x;
        pen_y = cfg.origin_y;
        chars_seen = 0;
        glyphs_drawn = 0;
      end
      if (chars_seen >= MAX_CHARS) return;
      chars_seen++;
      case (it.code)
        CHR_NL: begin
          pen_x = cfg.origin_x;
          pen_y = pen_y - {8'd0, cfg.line_height};
        end
        CHR_SPACE: pen_x = pen_x + {8'd0, cfg.space_width};
        CHR_TAB:   pen_x = pen_x + {6'd0, cfg.space_width, 2'b00};
        CHR_CR:    ;
        default: begin
          idx = int'(it.code) - int'(cfg.first_code);
          if (it.code >= 128 || it.code < cfg.first_code || it.code > cfg.last_code ||
              idx >= GLYPH_ENTRIES) begin
            pen_x = pen_x + {8'd0, cfg.space_width};
          end else begin
            g = glyph_mem[idx];
            r.screen_x     = pen_x;
            r.screen_y     = pen_y + {{7{g.descent[8]}}, g.descent};
            r.rect_width   = g.width;
            r.rect_height  = g.height;
            r.source_x     = g.tex_x;
            r.source_y     = g.tex_y;
            r.glyph_number = glyphs_drawn[9:0];
            pending_glyphs.push_back(r);
            pen_x = pen_x + {8'd0, g.width};
            glyphs_drawn++;
          end
        end
      endcase
    endfunction

    function void check_glyph(glyph_rect_t got);
      glyph_rect_t want;
      if (pending_glyphs.size() == 0) begin
        flag({"glyph with none expected: ", show(got)});
        return;
      end
      want = pending_glyphs.pop_front();
      if (got !== want) flag({"glyph mismatch\n  exp ", show(want), "\n  got ", show(got)});
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [7:0]  code_i;
  logic        starts_text_i;
  logic [11:0] load_tex_x_i;
  logic [11:0] load_tex_y_i;
  logic [7:0]  load_width_i;
  logic [7:0]  load_height_i;
  logic [8:0]  load_descent_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] screen_x_o;
  logic [15:0] screen_y_o;
  logic [7:0]  rect_width_o;
  logic [7:0]  rect_height_o;
  logic [11:0] source_x_o;
  logic [11:0] source_y_o;
  logic [9:0]  glyph_number_o;

  glyph_layout_scoreboard sb;
  bit                     loaded [GLYPH_ENTRIES];
  bit                     idle_on = 1'b1;

  bitmap_text_glyph_layout_core uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // all handshakes sampled at the falling edge, payload is stable there
  always @(negedge clk_i) begin
    glyph_rect_t  got;
    text_item_t   it;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{screen_x: screen_x_o, screen_y: screen_y_o, rect_width: rect_width_o,
                rect_height: rect_height_o, source_x: source_x_o, source_y: source_y_o,
                glyph_number: glyph_number_o};
        sb.check_glyph(got);
      end
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        it = '{kind: kind_i, code: code_i, starts: starts_text_i, tex_x: load_tex_x_i,
               tex_y: load_tex_y_i, width: load_width_i, height: load_height_i,
               descent: load_descent_i};
        sb.accept_item(it);
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic text_item_t random_item();
    return text_item_t'(ITEM_W'({$urandom, $urandom}));
  endfunction

  function automatic bit reads_unloaded(logic [7:0] c);
    if (c == CHR_NL || c == CHR_SPACE || c == CHR_TAB || c == CHR_CR) return 1'b0;
    if (c >= 128 || c < sb.cfg.first_code || c > sb.cfg.last_code) return 1'b0;
    return !loaded[int'(c) - int'(sb.cfg.first_code)];
  endfunction

  function automatic logic [7:0] pick_code(int unsigned draw_pct);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < draw_pct && sb.cfg.first_code <= sb.cfg.last_code)
      return 8'($urandom_range(sb.cfg.first_code, sb.cfg.last_code));
    case ($urandom_range(0, 9))
      0: return CHR_NL;
      1: return CHR_SPACE;
      2: return CHR_TAB;
      3: return CHR_CR;
      4, 5: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(text_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    if (it.kind == KIND_LOAD && it.code < GLYPH_ENTRIES) loaded[it.code] = 1'b1;
    in_valid_i     <= 1'b1;
    kind_i         <= it.kind;
    code_i         <= it.code;
    starts_text_i  <= it.starts;
    load_tex_x_i   <= it.tex_x;
    load_tex_y_i   <= it.tex_y;
    load_width_i   <= it.width;
    load_height_i  <= it.height;
    load_descent_i <= it.descent;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic load_entry(logic [7:0] idx, logic [11:0] tx, logic [11:0] ty,
                            logic [7:0] w, logic [7:0] h, logic [8:0] d, logic s);
    send_item('{kind: KIND_LOAD, code: idx, starts: s, tex_x: tx, tex_y: ty, width: w,
                height: h, descent: d});
  endtask

  task automatic send_char(logic [7:0] c, logic s);
    text_item_t it;
    text_item_t fill;
    if (reads_unloaded(c)) begin
      fill = random_item();
      load_entry(8'(int'(c) - int'(sb.cfg.first_code)), fill.tex_x, fill.tex_y, fill.width,
                 fill.height, fill.descent, fill.starts);
    end
    it = random_item();
    it.kind = KIND_TEXT;
    it.code = c;
    it.starts = s;
    send_item(it);
  endtask

  task automatic run_texts(int unsigned n_items, bit one_text);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    int unsigned p;
    text_item_t  it;
    sent = 0;
    while (sent < n_items) begin
      len = one_text ? n_items : $urandom_range(1, 40);
      for (k = 0; k < len && sent < n_items; k++) begin
        p = $urandom_range(0, 99);
        if (!one_text && p < 6) begin
          it = random_item();
          it.kind = KIND_LOAD;
          send_item(it);
        end else begin
          send_char(pick_code(one_text ? 90 : 55), k == 0 || (!one_text && p < 8));
        end
        sent++;
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // unused upper data bits carry noise
  task automatic program_layout(logic [15:0] ox, logic [15:0] oy, logic [6:0] fc,
                                logic [6:0] lc, logic [7:0] sw, logic [7:0] lh);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_FIRST_CODE, {9'($urandom), fc});
    write_reg(CFG_LAST_CODE, {9'($urandom), lc});
    write_reg(CFG_SPACE_WIDTH, {8'($urandom), sw});
    write_reg(CFG_LINE_HEIGHT, {8'($urandom), lh});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [6:0] fc;
    sb = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    kind_i         = 1'b0;
    code_i         = '0;
    starts_text_i  = 1'b0;
    load_tex_x_i   = '0;
    load_tex_y_i   = '0;
    load_width_i   = '0;
    load_height_i  = '0;
    load_descent_i = '0;
    out_ready_i    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and every character class at reset settings
    load_entry(8'd0, 12'hFFF, 12'h000, 8'hFF, 8'h00, 9'h100, 1'b1);
    load_entry(8'd93, 12'h000, 12'hFFF, 8'h00, 8'hFF, 9'h0FF, 1'b0);
    load_entry(8'd200, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 9'h1FF, 1'b0);
    load_entry(8'd127, 12'hAAA, 12'h555, 8'hA5, 8'h5A, 9'h1FF, 1'b0);
    send_char(8'd33, 1'b1);
    send_char(8'd126, 1'b0);
    send_char(CHR_SPACE, 1'b0);
    send_char(CHR_TAB, 1'b0);
    send_char(CHR_CR, 1'b0);
    send_char(CHR_NL, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'd32, 1'b0);
    send_char(8'd128, 1'b0);
    send_char(8'd255, 1'b0);
    send_char(8'd33, 1'b0);
    send_char(8'd65, 1'b1);
    send_char(8'd126, 1'b0);
    send_char(CHR_NL, 1'b0);
    send_char(8'd34, 1'b0);
    run_texts(100, 1'b0);
    settle();

    // full code range, wrapping origin, one text past the character limit
    program_layout(16'hFFFF, 16'hFFFF, 7'd0, 7'd127, 8'hFF, 8'hFF);
    run_texts(1040, 1'b1);
    run_texts(60, 1'b0);
    settle();

    program_layout(16'h0000, 16'h0000, 7'd127, 7'd127, 8'h00, 8'h00);
    run_texts(120, 1'b0);
    settle();

    // empty range
    program_layout(16'($urandom), 16'($urandom), 7'd100, 7'd20, 8'($urandom), 8'($urandom));
    run_texts(100, 1'b0);
    settle();

    // tab, newline and carriage return inside the drawable range
    program_layout(16'($urandom), 16'($urandom), 7'd8, 7'd14, 8'($urandom), 8'($urandom));
    run_texts(100, 1'b0);
    settle();

    fc = 7'($urandom);
    program_layout(16'($urandom), 16'($urandom), fc, 7'($urandom_range(fc, 127)),
                   8'($urandom), 8'($urandom));
    run_texts(120, 1'b0);
    settle();

    idle_on = 1'b0;
    program_layout(16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom),
                   8'($urandom), 8'($urandom));
    run_texts(150, 1'b0);
    settle();

    if (sb.pending_glyphs.size() != 0)
      sb.flag($sformatf("%0d glyphs never arrived", sb.pending_glyphs.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
